// ----- sv/ael_pkg.sv -----
// Shared types, character constants and classification helpers for the expression lexer.
package ael_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    KIND_NUM    = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_ADD    = 4'd2,
    KIND_SUB    = 4'd3,
    KIND_MUL    = 4'd4,
    KIND_DIV    = 4'd5,
    KIND_POW    = 4'd6,
    KIND_LPAREN = 4'd7,
    KIND_RPAREN = 4'd8
  } kind_t;

  // Scanner state
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_INT   = 3'd1,
    ST_FRAC  = 3'd2,
    ST_DOT   = 3'd3,
    ST_IDENT = 3'd4,
    ST_DROP  = 3'd5
  } scan_state_t;

  // ASCII codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // One result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic       token_start;
    logic       token_end;
    logic       error;
    logic       run_last;
  } res_t;

  // Results of one accepted input beat, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  endfunction

  // Tab, LF, VT, FF, CR or space
  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_CARET) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic kind_t op_kind(logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:   k = KIND_ADD;
      CH_MINUS:  k = KIND_SUB;
      CH_STAR:   k = KIND_MUL;
      CH_SLASH:  k = KIND_DIV;
      CH_CARET:  k = KIND_POW;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_NUM;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(kind_t k, logic [7:0] c, logic s, logic e, logic er);
    res_t r;
    r.kind        = k;
    r.chr         = c;
    r.token_start = s;
    r.token_end   = e;
    r.error       = er;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/ael_ifs.sv -----
// Valid/ready channel interfaces for the lexer's character input and token output.
interface ael_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink (input valid, input ch, input last_char, output ready);
endinterface

interface ael_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] out_char;
  logic       token_start;
  logic       token_end;
  logic       error;
  logic       run_last;

  modport source (output valid, output kind, output out_char, output token_start,
                  output token_end, output error, output run_last, input ready);
  modport sink (input valid, input kind, input out_char, input token_start,
                input token_end, input error, input run_last, output ready);
endinterface

// ----- sv/ael_step.sv -----
// Scanner: state and held character, and the up to two results of each input beat.
module ael_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          last_char,
  output ael_pkg::push_t push
);
  import ael_pkg::*;

  scan_state_t state_r, state_nxt;
  logic [7:0]  held_char_r, held_char_nxt;
  kind_t       held_kind_r, held_kind_nxt;
  logic        held_start_r, held_start_nxt;
  logic        held_valid_r, held_valid_nxt;

  res_t        res_a [2];
  logic [1:0]  n;
  logic        from_idle;

  // Next state and results for the current beat
  always_comb begin
    state_nxt      = state_r;
    held_char_nxt  = held_char_r;
    held_kind_nxt  = held_kind_r;
    held_start_nxt = held_start_r;
    held_valid_nxt = held_valid_r;
    res_a[0]       = '0;
    res_a[1]       = '0;
    n              = 2'd0;
    from_idle      = 1'b0;

    unique case (state_r)
      ST_DROP: begin
      end
      ST_DOT: begin
        if (is_digit(ch)) begin
          res_a[n[0]] = mk_res(held_kind_r, held_char_r, held_start_r, 1'b0, 1'b0);
          n = n + 2'd1;
          held_char_nxt  = ch;
          held_kind_nxt  = KIND_NUM;
          held_start_nxt = 1'b0;
          held_valid_nxt = 1'b1;
          state_nxt      = ST_FRAC;
        end else begin
          // lone point
          res_a[n[0]] = mk_res(KIND_NUM, held_char_r, 1'b0, 1'b0, 1'b1);
          n = n + 2'd1;
          held_valid_nxt = 1'b0;
          state_nxt      = ST_DROP;
        end
      end
      ST_INT, ST_FRAC: begin
        if (is_digit(ch) || ((state_r == ST_INT) && (ch == CH_DOT))) begin
          res_a[n[0]] = mk_res(held_kind_r, held_char_r, held_start_r, 1'b0, 1'b0);
          n = n + 2'd1;
          held_char_nxt  = ch;
          held_kind_nxt  = KIND_NUM;
          held_start_nxt = 1'b0;
          held_valid_nxt = 1'b1;
          state_nxt      = (is_digit(ch) && (state_r == ST_INT)) ? ST_INT : ST_FRAC;
        end else begin
          res_a[n[0]] = mk_res(held_kind_r, held_char_r, held_start_r, 1'b1, 1'b0);
          n = n + 2'd1;
          held_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
          from_idle      = 1'b1;
        end
      end
      ST_IDENT: begin
        if (is_lower(ch)) begin
          res_a[n[0]] = mk_res(held_kind_r, held_char_r, held_start_r, 1'b0, 1'b0);
          n = n + 2'd1;
          held_char_nxt  = ch;
          held_kind_nxt  = KIND_IDENT;
          held_start_nxt = 1'b0;
          held_valid_nxt = 1'b1;
          state_nxt      = ST_IDENT;
        end else begin
          res_a[n[0]] = mk_res(held_kind_r, held_char_r, held_start_r, 1'b1, 1'b0);
          n = n + 2'd1;
          held_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
          from_idle      = 1'b1;
        end
      end
      default: begin
        held_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
        from_idle      = 1'b1;
      end
    endcase

    // Start of a new token, or a separator, operator or bad byte
    if (from_idle) begin
      priority if (is_digit(ch)) begin
        held_char_nxt  = ch;
        held_kind_nxt  = KIND_NUM;
        held_start_nxt = 1'b1;
        held_valid_nxt = 1'b1;
        state_nxt      = ST_INT;
      end else if (ch == CH_DOT) begin
        held_char_nxt  = ch;
        held_kind_nxt  = KIND_NUM;
        held_start_nxt = 1'b1;
        held_valid_nxt = 1'b1;
        state_nxt      = ST_DOT;
      end else if (is_lower(ch)) begin
        held_char_nxt  = ch;
        held_kind_nxt  = KIND_IDENT;
        held_start_nxt = 1'b1;
        held_valid_nxt = 1'b1;
        state_nxt      = ST_IDENT;
      end else if (is_space(ch)) begin
      end else if (is_op(ch)) begin
        res_a[n[0]] = mk_res(op_kind(ch), ch, 1'b1, 1'b1, 1'b0);
        n = n + 2'd1;
      end else begin
        res_a[n[0]] = mk_res(KIND_NUM, ch, 1'b0, 1'b0, 1'b1);
        n = n + 2'd1;
        held_valid_nxt = 1'b0;
        state_nxt      = ST_DROP;
      end
    end

    // End of expression: flush what is held and go idle
    if (last_char) begin
      if (held_valid_nxt) begin
        if (state_nxt == ST_DOT) begin
          res_a[n[0]] = mk_res(KIND_NUM, held_char_nxt, 1'b0, 1'b0, 1'b1);
        end else begin
          res_a[n[0]] = mk_res(held_kind_nxt, held_char_nxt, held_start_nxt, 1'b1, 1'b0);
        end
        n = n + 2'd1;
      end
      held_valid_nxt = 1'b0;
      state_nxt      = ST_IDLE;
    end

    // Mark the final result of this beat
    if (n == 2'd1) begin
      res_a[0].run_last = 1'b1;
    end
    if (n == 2'd2) begin
      res_a[1].run_last = 1'b1;
    end

    push.cnt = accept ? n : 2'd0;
    push.r0  = res_a[0];
    push.r1  = res_a[1];
  end

  // Scanner registers advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_char_r  <= '0;
      held_kind_r  <= KIND_NUM;
      held_start_r <= 1'b0;
      held_valid_r <= 1'b0;
    end else if (accept) begin
      state_r      <= state_nxt;
      held_char_r  <= held_char_nxt;
      held_kind_r  <= held_kind_nxt;
      held_start_r <= held_start_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

// ----- sv/ael_queue.sv -----
// Four-entry result queue: takes up to two results per cycle, sends one beat per cycle while out_bus.ready is high.
module ael_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  ael_pkg::push_t  push,
  output logic            space_ok,
  ael_out_if.source       out_bus
);
  import ael_pkg::*;

  res_t       q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // Pointer and fill count update
  always_comb begin
    pop        = (cnt_r != 3'd0) && out_bus.ready;
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
    space_ok   = (cnt_r <= 3'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  // Head of queue drives the output channel
  always_comb begin
    out_bus.valid       = (cnt_r != 3'd0);
    out_bus.kind        = q_r[rd_ptr_r].kind;
    out_bus.out_char    = q_r[rd_ptr_r].chr;
    out_bus.token_start = q_r[rd_ptr_r].token_start;
    out_bus.token_end   = q_r[rd_ptr_r].token_end;
    out_bus.error       = q_r[rd_ptr_r].error;
    out_bus.run_last    = q_r[rd_ptr_r].run_last;
  end

endmodule

// ----- sv/arithmetic_expression_lexer.sv -----
// Expression lexer top level: scanner feeding a result queue.
// Results: each result is written into the result queue on the input beat that releases it; a number
//   or identifier character is released by the next character or by its own last_char beat.
// Throughput: one input beat per cycle while the 4-entry result queue holds at most two
//   results; the queue drains one beat per cycle while ready, so two-result beats slow input.
// Reset: synchronous active-low rst_n clears the scanner to idle and empties the queue.
module arithmetic_expression_lexer (
  input  logic      clk,
  input  logic      rst_n,
  ael_in_if.sink    in_bus,
  ael_out_if.source out_bus
);
  import ael_pkg::*;

  push_t push;
  logic  space_ok;
  logic  accept;

  // Input handshake
  assign in_bus.ready = space_ok;
  assign accept       = in_bus.valid && space_ok;

  ael_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_bus.ch),
    .last_char (in_bus.last_char),
    .push      (push)
  );

  ael_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_bus  (out_bus)
  );

endmodule

// ----- bench/ael_token_checker.sv -----
// Token checker for the expression lexer: follows both channels, predicts each token beat and compares.
`timescale 1ns / 100ps

module ael_token_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_kind,
  input  logic [7:0] out_char,
  input  logic       out_token_start,
  input  logic       out_token_end,
  input  logic       out_error,
  input  logic       out_run_last,
  output int         fail_count,
  output int         pending,
  output int         tokens_checked,
  output int         error_beats
);
  import ael_pkg::*;

  // Scanner copy: state, held character and its labels
  scan_state_t lx_state;
  logic [7:0]  lx_char;
  kind_t       lx_kind;
  logic        lx_start;
  logic        lx_held;

  res_t step_toks[$];     // beats produced by the character being scanned
  res_t expected_toks[$]; // beats still owed by the block, oldest first

  function automatic void emit_tok(kind_t k, logic [7:0] c, logic s, logic e, logic er);
    res_t r;
    r.kind        = k;
    r.chr         = c;
    r.token_start = s;
    r.token_end   = e;
    r.error       = er;
    r.run_last    = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic void hold_char(logic [7:0] c, kind_t k, logic s, scan_state_t st);
    lx_char  = c;
    lx_kind  = k;
    lx_start = s;
    lx_held  = 1'b1;
    lx_state = st;
  endfunction

  function automatic void release_held(logic e);
    emit_tok(lx_kind, lx_char, lx_start, e, 1'b0);
    lx_held  = 1'b0;
    lx_state = ST_IDLE;
  endfunction

  function automatic void start_drop();
    lx_held  = 1'b0;
    lx_state = ST_DROP;
  endfunction

  // Character seen between tokens
  function automatic void scan_fresh(logic [7:0] c);
    kind_t k;
    logic  single;
    single = 1'b1;
    case (c)
      CH_PLUS:   k = KIND_ADD;
      CH_MINUS:  k = KIND_SUB;
      CH_STAR:   k = KIND_MUL;
      CH_SLASH:  k = KIND_DIV;
      CH_CARET:  k = KIND_POW;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default: begin
        k      = KIND_NUM;
        single = 1'b0;
      end
    endcase
    if (c >= CH_ZERO && c <= CH_NINE) begin
      hold_char(c, KIND_NUM, 1'b1, ST_INT);
    end else if (c == CH_DOT) begin
      hold_char(c, KIND_NUM, 1'b1, ST_DOT);
    end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      hold_char(c, KIND_IDENT, 1'b1, ST_IDENT);
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      // separator, no beat
    end else if (single) begin
      emit_tok(k, c, 1'b1, 1'b1, 1'b0);
    end else begin
      emit_tok(KIND_NUM, c, 1'b0, 1'b0, 1'b1);
      start_drop();
    end
  endfunction

  // Advance the scanner by one character and queue the beats it owes
  function automatic void lex_char(logic [7:0] c, logic last);
    logic digit;
    logic lower;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    step_toks.delete();
    case (lx_state)
      ST_DROP: ;
      ST_DOT: begin
        if (digit) begin
          release_held(1'b0);
          hold_char(c, KIND_NUM, 1'b0, ST_FRAC);
        end else begin
          // lone point: report it, the revealing character goes
          emit_tok(KIND_NUM, lx_char, 1'b0, 1'b0, 1'b1);
          start_drop();
        end
      end
      ST_INT: begin
        if (digit) begin
          release_held(1'b0);
          hold_char(c, KIND_NUM, 1'b0, ST_INT);
        end else if (c == CH_DOT) begin
          release_held(1'b0);
          hold_char(c, KIND_NUM, 1'b0, ST_FRAC);
        end else begin
          release_held(1'b1);
          scan_fresh(c);
        end
      end
      ST_FRAC: begin
        // a second point closes the number and opens a new one
        if (digit) begin
          release_held(1'b0);
          hold_char(c, KIND_NUM, 1'b0, ST_FRAC);
        end else begin
          release_held(1'b1);
          scan_fresh(c);
        end
      end
      ST_IDENT: begin
        if (lower) begin
          release_held(1'b0);
          hold_char(c, KIND_IDENT, 1'b0, ST_IDENT);
        end else begin
          release_held(1'b1);
          scan_fresh(c);
        end
      end
      default: begin
        lx_held  = 1'b0;
        lx_state = ST_IDLE;
        scan_fresh(c);
      end
    endcase

    // end of expression: flush whatever is held
    if (last) begin
      if (lx_held) begin
        if (lx_state == ST_DOT) emit_tok(KIND_NUM, lx_char, 1'b0, 1'b0, 1'b1);
        else release_held(1'b1);
      end
      lx_held  = 1'b0;
      lx_state = ST_IDLE;
    end

    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_last = 1'b1;
    foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
  endfunction

  // Output side first: a beat never stems from the input beat of the same edge
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      lx_state = ST_IDLE;
      lx_char  = 8'h00;
      lx_kind  = KIND_NUM;
      lx_start = 1'b0;
      lx_held  = 1'b0;
      expected_toks.delete();
    end else begin
      if (out_valid && out_ready) begin
        tokens_checked++;
        if (out_error) error_beats++;
        if (expected_toks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected beat kind %0d char %02h start %b end %b err %b last %b",
                     $realtime, out_kind, out_char, out_token_start, out_token_end,
                     out_error, out_run_last);
        end else begin
          want = expected_toks.pop_front();
          if (out_kind !== want.kind || out_char !== want.chr ||
              out_token_start !== want.token_start || out_token_end !== want.token_end ||
              out_error !== want.error || out_run_last !== want.run_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: beat mismatch, expected kind %0d char %02h start %b end %b ",
                        "err %b last %b, got kind %0d char %02h start %b end %b err %b last %b"},
                       $realtime, want.kind, want.chr, want.token_start, want.token_end,
                       want.error, want.run_last, out_kind, out_char, out_token_start,
                       out_token_end, out_error, out_run_last);
          end
        end
      end
      if (in_valid && in_ready) lex_char(in_ch, in_last_char);
    end
    pending = expected_toks.size();
  end

endmodule

// ----- bench/arithmetic_expression_lexer_test.sv -----
// Testbench top for the expression lexer: clock, reset, character stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module arithmetic_expression_lexer_test;
  import ael_pkg::*;

  localparam int FEED_TARGET  = 600;
  localparam int PHASE_A_END  = 200;
  localparam int PHASE_B_END  = 400;
  localparam int STALL_AT     = 300;
  localparam int STALL_LEN    = 120;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fed           = 0;
  int exprs         = 0;
  int fail_count;
  int pending;
  int tokens_checked;
  int error_beats;
  int quiet_cycles  = 0;
  int stall_left    = 0;
  bit stall_done    = 1'b0;

  logic [7:0] expr_chars[$];

  ael_in_if  in_bus ();
  ael_out_if out_bus ();

  arithmetic_expression_lexer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  ael_token_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_bus.valid),
    .in_ready       (in_bus.ready),
    .in_ch          (in_bus.ch),
    .in_last_char   (in_bus.last_char),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_kind       (out_bus.kind),
    .out_char       (out_bus.out_char),
    .out_token_start(out_bus.token_start),
    .out_token_end  (out_bus.token_end),
    .out_error      (out_bus.error),
    .out_run_last   (out_bus.run_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked),
    .error_beats    (error_beats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one character beat, with a random gap first, and wait for its handshake
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.ch        <= c;
    in_bus.last_char <= last;
    do @(posedge clk); while (!in_bus.ready);
    fed++;
    if (last) exprs++;
  endtask

  task automatic send_text(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], mark_last && (i == s.len() - 1));
  endtask

  function automatic void push_digits(int n);
    for (int i = 0; i < n; i++) expr_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  // Mostly well-formed expressions; stray bytes and lone points now and then
  task automatic send_random_expr();
    int ntok;
    ntok = $urandom_range(10, 1);
    expr_chars.delete();
    for (int t = 0; t < ntok; t++) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 32) begin
        case ($urandom_range(3))
          0: push_digits($urandom_range(4, 1));
          1: begin
            push_digits($urandom_range(3, 1));
            expr_chars.push_back(CH_DOT);
          end
          2: begin
            push_digits($urandom_range(3, 1));
            expr_chars.push_back(CH_DOT);
            push_digits($urandom_range(3, 1));
          end
          default: begin
            expr_chars.push_back(CH_DOT);
            push_digits($urandom_range(3, 1));
          end
        endcase
      end else if (sel < 52) begin
        for (int i = $urandom_range(4, 1); i > 0; i--)
          expr_chars.push_back(CH_LOW_A + 8'($urandom_range(25)));
      end else if (sel < 74) begin
        case ($urandom_range(6))
          0: expr_chars.push_back(CH_PLUS);
          1: expr_chars.push_back(CH_MINUS);
          2: expr_chars.push_back(CH_STAR);
          3: expr_chars.push_back(CH_SLASH);
          4: expr_chars.push_back(CH_CARET);
          5: expr_chars.push_back(CH_LPAREN);
          default: expr_chars.push_back(CH_RPAREN);
        endcase
      end else if (sel < 90) begin
        if ($urandom_range(5) == 0) expr_chars.push_back(CH_SPACE);
        else expr_chars.push_back(CH_TAB + 8'($urandom_range(4)));
      end else if (sel < 93) begin
        expr_chars.push_back(CH_DOT);
      end else if (sel < 96) begin
        // point after a fraction
        push_digits(1);
        expr_chars.push_back(CH_DOT);
        push_digits(1);
        expr_chars.push_back(CH_DOT);
        push_digits($urandom_range(2, 1));
      end else begin
        expr_chars.push_back(8'($urandom_range(255)));
      end
    end
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // Receiver: random ready, plus one long hold-off once the feed passes STALL_AT
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!stall_done && fed >= STALL_AT) begin
        stall_left = STALL_LEN;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Watchdog: no beat for %0d cycles, %0d beats still owed",
                   quiet_cycles, pending);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.ch        <= 8'h00;
    in_bus.last_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Phase A: sender mostly busy, receiver mostly idle
    send_idle_pct = 27;
    recv_idle_pct = 74;

    // Directed: number forms, operators, separators, errors and dropping
    send_text("9.1.5*zq", 1'b1);
    send_text("(a\t+.)", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(CH_MINUS, 1'b1);
    send_text("7)^/", 1'b0);
    send_char(8'hFF, 1'b1);
    send_text(".", 1'b1);
    send_text(" 3", 1'b1);

    while (fed < PHASE_A_END) send_random_expr();

    // Phase B: roles swapped; the long receiver hold-off falls here
    send_idle_pct = 74;
    recv_idle_pct = 27;
    while (fed < PHASE_B_END) send_random_expr();

    // Phase C: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (fed < FEED_TARGET) send_random_expr();

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d characters in %0d expressions, %0d token beats checked (%0d errors).",
             fed, exprs, tokens_checked, error_beats);
    $display("Ran skewed, reversed and free-running backpressure plus a %0d-cycle output stall.",
             STALL_LEN);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
